[rtl/guillotine_box_placer_3d_defines.svh]
// Assertion macros shared by the guillotine box placer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef GUILLOTINE_BOX_PLACER_3D_DEFINES_SVH
`define GUILLOTINE_BOX_PLACER_3D_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GBP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("guillotine box placer check failed");

// Next-cycle implication, disabled during reset.
`define GBP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("guillotine box placer check failed");

`endif

[rtl/gbp_pkg.sv]
// Shared types and constants of the guillotine box placer.
// No dependencies; used by gbp_ctrl, gbp_dpath and the top level.
package gbp_pkg;

  localparam int DIM_W = 16;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BIN_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_BIN_DEPTH  = 2'd1;
  localparam logic [1:0] CFG_SPLIT_RULE = 2'd2;

  // Split rules.
  localparam logic [1:0] RULE_SHORT_LEFT = 2'd0;
  localparam logic [1:0] RULE_LONG_LEFT  = 2'd1;
  localparam logic [1:0] RULE_SHORT_AXIS = 2'd2;
  localparam logic [1:0] RULE_LONG_AXIS  = 2'd3;

  // Request kinds.
  localparam logic KIND_NEW_BIN = 1'b0;
  localparam logic KIND_PLACE   = 1'b1;

  // Slots of the three appended free boxes.
  localparam logic [1:0] PUSH_BOTTOM = 2'd0;
  localparam logic [1:0] PUSH_RIGHT  = 2'd1;
  localparam logic [1:0] PUSH_TOP    = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       init_bin;
    logic       step;
    logic       split;
    logic       push;
    logic [1:0] push_sel;
    logic       emit;
  } gbp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic place;
    logic full;
    logic step_done;
    logic found;
  } gbp_status_t;

endpackage

[rtl/gbp_ctrl.sv]
// Sequencer of the guillotine box placer: handshakes and command issue.
// Depends on gbp_pkg and guillotine_box_placer_3d_defines.svh.
`include "guillotine_box_placer_3d_defines.svh"

module gbp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output gbp_pkg::gbp_cmd_t   cmd,
  input  gbp_pkg::gbp_status_t status
);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_DECIDE, ST_NEW_BIN, ST_SCAN, ST_SPLIT, ST_SHIFT,
    ST_PUSH0, ST_PUSH1, ST_PUSH2, ST_RESULT
  } state_t;

  state_t state;
  logic   accept;
  logic   emit_ok;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign emit_ok  = (state == ST_RESULT) && (!out_valid || !out_stall);

  // Command decode from the current state.
  always_comb begin
    cmd          = '0;
    cmd.load     = accept;
    cmd.init_bin = (state == ST_INIT) || (state == ST_NEW_BIN);
    cmd.step     = (state == ST_SCAN) || (state == ST_SHIFT);
    cmd.split    = (state == ST_SPLIT);
    cmd.push     = (state == ST_PUSH0) || (state == ST_PUSH1) || (state == ST_PUSH2);
    cmd.emit     = emit_ok;
    unique case (state)
      ST_PUSH1: cmd.push_sel = gbp_pkg::PUSH_RIGHT;
      ST_PUSH2: cmd.push_sel = gbp_pkg::PUSH_TOP;
      default:  cmd.push_sel = gbp_pkg::PUSH_BOTTOM;
    endcase
  end

  // State register and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      out_valid <= 1'b0;
    end else begin
      if (emit_ok) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_INIT: state <= ST_IDLE;
        ST_IDLE: begin
          if (accept) state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (!status.place) state <= ST_NEW_BIN;
          else if (status.full) state <= ST_RESULT;
          else state <= ST_SCAN;
        end
        ST_NEW_BIN: state <= ST_RESULT;
        ST_SCAN: begin
          if (status.step_done) state <= status.found ? ST_SPLIT : ST_RESULT;
        end
        ST_SPLIT: state <= ST_SHIFT;
        ST_SHIFT: begin
          if (status.step_done) state <= ST_PUSH0;
        end
        ST_PUSH0: state <= ST_PUSH1;
        ST_PUSH1: state <= ST_PUSH2;
        ST_PUSH2: state <= ST_RESULT;
        ST_RESULT: begin
          if (emit_ok) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `GBP_ASSERT_NEXT(a_emit_sets_valid, clk, rst, emit_ok, out_valid)
  `GBP_ASSERT_NOW(a_split_needs_found, clk, rst, state == ST_SPLIT, status.found)
  `GBP_ASSERT_NEXT(a_valid_held, clk, rst, out_valid && out_stall, out_valid)

endmodule

[rtl/gbp_dpath.sv]
// Datapath of the guillotine box placer: free list memory, scan, split, result.
// Depends on gbp_pkg and guillotine_box_placer_3d_defines.svh.
`include "guillotine_box_placer_3d_defines.svh"

module gbp_dpath #(
  parameter int MAX_FREE    = 64,
  parameter int HEIGHT_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [15:0]                 cfg_data,
  input  logic                        kind,
  input  logic [15:0]                 box_width,
  input  logic [15:0]                 box_height,
  input  logic [15:0]                 box_depth,
  input  gbp_pkg::gbp_cmd_t           cmd,
  output gbp_pkg::gbp_status_t        status,
  output logic                        placed,
  output logic                        table_full,
  output logic [15:0]                 pos_x,
  output logic [HEIGHT_BITS-1:0]      pos_y,
  output logic [15:0]                 pos_z,
  output logic [15:0]                 placed_width,
  output logic [15:0]                 placed_height,
  output logic [15:0]                 placed_depth
);

  localparam int HB    = HEIGHT_BITS;
  localparam int DW    = gbp_pkg::DIM_W;
  localparam int IDX_W = $clog2(MAX_FREE);
  localparam int CNT_W = $clog2(MAX_FREE + 1);
  localparam int ENT_W = 4 * DW + 2 * HB;
  localparam logic [HB-1:0] HMAX = {HB{1'b1}};
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FREE);

  // Entry layout: x, y, z, w, h, d from the top.
  localparam int D_LO = 0;
  localparam int H_LO = DW;
  localparam int W_LO = DW + HB;
  localparam int Z_LO = 2 * DW + HB;
  localparam int Y_LO = 3 * DW + HB;
  localparam int X_LO = 3 * DW + 2 * HB;

  // Configuration registers.
  logic [DW-1:0] bin_w, bin_d;
  logic [1:0]    rule;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_w <= DW'(1024);
      bin_d <= DW'(1024);
      rule  <= gbp_pkg::RULE_SHORT_LEFT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gbp_pkg::CFG_BIN_WIDTH:  bin_w <= cfg_data;
        gbp_pkg::CFG_BIN_DEPTH:  bin_d <= cfg_data;
        gbp_pkg::CFG_SPLIT_RULE: rule  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Free list memory, one write and one registered read per cycle.
  logic [ENT_W-1:0] mem [MAX_FREE];
  logic [ENT_W-1:0] rdata, wdata;
  logic [IDX_W-1:0] raddr, waddr;
  logic             we;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // Item and search registers.
  logic             kind_q, full_q;
  logic [DW-1:0]    bw, bh, bd;
  logic [CNT_W-1:0] count, ptr;
  logic             pend;
  logic             shifting;
  logic [IDX_W-1:0] pidx;
  logic             found;
  logic [HB:0]      best_score;
  logic [IDX_W-1:0] best_idx;
  logic [ENT_W-1:0] best_ent;
  logic [DW-1:0]    pw, ph, pd;
  logic [ENT_W-1:0] n0, n1, n2;
  logic             issue;

  assign issue = cmd.step && (ptr < count);
  assign raddr = ptr[IDX_W-1:0];

  // Fields of the entry being scanned.
  logic [DW-1:0] e_w, e_d;
  logic [HB-1:0] e_y, e_h;
  assign e_y = rdata[Y_LO +: HB];
  assign e_w = rdata[W_LO +: DW];
  assign e_h = rdata[H_LO +: HB];
  assign e_d = rdata[D_LO +: DW];

  // Six orientations checked in parallel; the lowest fitting one is taken.
  logic [DW-1:0] ow [6];
  logic [DW-1:0] oh [6];
  logic [DW-1:0] od [6];
  logic [5:0]    fit;
  logic          fit_any;
  logic [DW-1:0] sw, sh, sd;
  logic [HB:0]   score;

  always_comb begin
    ow[0] = bw; oh[0] = bh; od[0] = bd;
    ow[1] = bw; oh[1] = bd; od[1] = bh;
    ow[2] = bd; oh[2] = bh; od[2] = bw;
    ow[3] = bd; oh[3] = bw; od[3] = bh;
    ow[4] = bh; oh[4] = bw; od[4] = bd;
    ow[5] = bh; oh[5] = bd; od[5] = bw;
    sw = '0; sh = '0; sd = '0;
    for (int k = 0; k < 6; k++) begin
      fit[k] = (ow[k] <= e_w) && (HB'(oh[k]) <= e_h) && (od[k] <= e_d) &&
               (({1'b0, e_y} + (HB + 1)'(oh[k])) <= {1'b0, HMAX});
    end
    for (int k = 5; k >= 0; k--) begin
      if (fit[k]) begin
        sw = ow[k]; sh = oh[k]; sd = od[k];
      end
    end
    fit_any = |fit;
    score   = {1'b0, e_y} + (HB + 1)'(bh);
  end

  // Split of the chosen free box.
  logic [DW-1:0] f_x, f_z, f_w, f_d, left_w, left_d;
  logic [HB-1:0] f_y, f_h, top_h;
  logic          horiz;

  always_comb begin
    f_x    = best_ent[X_LO +: DW];
    f_y    = best_ent[Y_LO +: HB];
    f_z    = best_ent[Z_LO +: DW];
    f_w    = best_ent[W_LO +: DW];
    f_h    = best_ent[H_LO +: HB];
    f_d    = best_ent[D_LO +: DW];
    left_w = f_w - pw;
    left_d = f_d - pd;
    case (rule)
      gbp_pkg::RULE_SHORT_LEFT: horiz = left_w <= left_d;
      gbp_pkg::RULE_LONG_LEFT:  horiz = left_w > left_d;
      gbp_pkg::RULE_SHORT_AXIS: horiz = f_w <= f_d;
      default:                  horiz = f_w > f_d;
    endcase
    top_h = (f_h == HMAX) ? HMAX : (f_h - HB'(ph));
  end

  // Memory write selection.
  logic [CNT_W-1:0] push_addr;
  always_comb begin
    push_addr = count - CNT_W'(1) + CNT_W'(cmd.push_sel);
    we    = 1'b0;
    waddr = pidx;
    wdata = rdata;
    if (cmd.init_bin) begin
      we    = 1'b1;
      waddr = '0;
      wdata = {DW'(0), HB'(0), DW'(0), bin_w, HMAX, bin_d};
    end else if (cmd.push) begin
      we    = 1'b1;
      waddr = push_addr[IDX_W-1:0];
      case (cmd.push_sel)
        gbp_pkg::PUSH_BOTTOM: wdata = n0;
        gbp_pkg::PUSH_RIGHT:  wdata = n1;
        default:              wdata = n2;
      endcase
    end else if (cmd.step && pend && shifting) begin
      we = 1'b1;
    end
  end

  // Sequencing registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= CNT_W'(1);
      ptr      <= '0;
      pend     <= 1'b0;
      found    <= 1'b0;
      shifting <= 1'b0;
    end else begin
      if (cmd.load) begin
        ptr      <= '0;
        pend     <= 1'b0;
        found    <= 1'b0;
        shifting <= 1'b0;
      end
      if (cmd.init_bin) count <= CNT_W'(1);
      if (cmd.step) begin
        pend <= issue;
        if (issue) ptr <= ptr + CNT_W'(1);
        if (pend && !shifting && fit_any && (!found || score < best_score)) begin
          found <= 1'b1;
        end
      end
      if (cmd.split) begin
        ptr      <= CNT_W'(best_idx) + CNT_W'(1);
        pend     <= 1'b0;
        shifting <= 1'b1;
      end
      if (cmd.push && cmd.push_sel == gbp_pkg::PUSH_TOP) count <= count + CNT_W'(2);
    end
  end

  // Payload registers of the search and split.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= kind;
      full_q <= count > (MAX_CNT - CNT_W'(2));
      bw     <= box_width;
      bh     <= box_height;
      bd     <= box_depth;
    end
    if (issue) pidx <= ptr[IDX_W-1:0] - ((shifting) ? IDX_W'(1) : IDX_W'(0));
    if (cmd.step && pend && !shifting && fit_any && (!found || score < best_score)) begin
      best_score <= score;
      best_idx   <= pidx;
      best_ent   <= rdata;
      pw <= sw; ph <= sh; pd <= sd;
    end
    if (cmd.split) begin
      n0 <= {f_x, f_y, f_z + pd, horiz ? f_w : pw, HB'(ph), left_d};
      n1 <= {f_x + pw, f_y, f_z, left_w, HB'(ph), horiz ? pd : f_d};
      n2 <= {f_x, f_y + HB'(ph), f_z, f_w, top_h, f_d};
    end
  end

  // Status to the controller.
  assign status.place     = (kind_q == gbp_pkg::KIND_PLACE);
  assign status.full      = full_q;
  assign status.step_done = (ptr == count) && !pend;
  assign status.found     = found;

  // Result register.
  logic res_placed;
  assign res_placed = (kind_q == gbp_pkg::KIND_PLACE) && !full_q && found;

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      placed        <= res_placed;
      table_full    <= (kind_q == gbp_pkg::KIND_PLACE) && full_q;
      pos_x         <= res_placed ? f_x : '0;
      pos_y         <= res_placed ? f_y : '0;
      pos_z         <= res_placed ? f_z : '0;
      placed_width  <= res_placed ? pw : '0;
      placed_height <= res_placed ? ph : '0;
      placed_depth  <= res_placed ? pd : '0;
    end
  end

  `GBP_ASSERT_NOW(a_count_range, clk, rst, 1'b1, (count != '0) && (count <= MAX_CNT))
  `GBP_ASSERT_NOW(a_pend_issued, clk, rst, pend, ptr != '0)
  `GBP_ASSERT_NOW(a_push_in_range, clk, rst, cmd.push, push_addr < MAX_CNT)

endmodule

[rtl/guillotine_box_placer_3d.sv]
// Top level of the guillotine box placer: controller plus datapath.
// Depends on gbp_pkg, gbp_ctrl and gbp_dpath.
//
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | kind, box_width, box_height, box_depth
//  out     | out_valid/out_stall| placed, table_full, pos_*, placed_*
//  cfg     | cfg_we             | cfg_index, cfg_data
//
// With N free boxes in the list, a placement scans the list and then compacts it,
// with one memory read per cycle for the scan and again for the compaction that follows.
// A request that fits nowhere only scans; a new-bin request and a refusal do neither.
// After reset the block writes the whole-bin entry before it takes its first request.
// A new item is taken while the last result still waits in the output register.

module guillotine_box_placer_3d #(
  parameter int MAX_FREE    = 64,
  parameter int HEIGHT_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   kind,
  input  logic [15:0]            box_width,
  input  logic [15:0]            box_height,
  input  logic [15:0]            box_depth,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   placed,
  output logic                   table_full,
  output logic [15:0]            pos_x,
  output logic [HEIGHT_BITS-1:0] pos_y,
  output logic [15:0]            pos_z,
  output logic [15:0]            placed_width,
  output logic [15:0]            placed_height,
  output logic [15:0]            placed_depth
);

  gbp_pkg::gbp_cmd_t    cmd;
  gbp_pkg::gbp_status_t status;

  gbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  gbp_dpath #(
    .MAX_FREE    (MAX_FREE),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .kind          (kind),
    .box_width     (box_width),
    .box_height    (box_height),
    .box_depth     (box_depth),
    .cmd           (cmd),
    .status        (status),
    .placed        (placed),
    .table_full    (table_full),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .placed_width  (placed_width),
    .placed_height (placed_height),
    .placed_depth  (placed_depth)
  );

endmodule

[verif/gbp_place_checker.sv]
// Scoreboard for the guillotine box placer: it watches both channels and the register port.
// It predicts every result from its own copy of the free list and counts mismatches.
// Depends on gbp_pkg for the request kinds, register indexes and split rules.
`timescale 1ns / 1ps

module gbp_place_checker #(
  parameter int LIST_SIZE   = 64,
  parameter int HEIGHT_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic                   kind,
  input  logic [15:0]            box_width,
  input  logic [15:0]            box_height,
  input  logic [15:0]            box_depth,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic                   placed,
  input  logic                   table_full,
  input  logic [15:0]            pos_x,
  input  logic [HEIGHT_BITS-1:0] pos_y,
  input  logic [15:0]            pos_z,
  input  logic [15:0]            placed_width,
  input  logic [15:0]            placed_height,
  input  logic [15:0]            placed_depth,
  output int                     errors,
  output int                     outstanding
);

  localparam logic [31:0] HEIGHT_TOP = (32'd1 << HEIGHT_BITS) - 32'd1;

  typedef struct {
    logic [31:0] x, y, z;
    logic [31:0] w, h, d;
  } free_box_t;

  typedef struct {
    logic                   placed;
    logic                   full;
    logic [15:0]            x;
    logic [HEIGHT_BITS-1:0] y;
    logic [15:0]            z;
    logic [15:0]            w, h, d;
  } placement_t;

  free_box_t   free_list [LIST_SIZE];
  int          free_n;
  logic [15:0] width_reg, depth_reg;
  logic [1:0]  rule_reg;
  placement_t  placements_due [$];

  assign outstanding = placements_due.size();

  // Refill the list with one box covering the bin.
  function automatic void open_bin();
    free_list[0] = '{x: 32'd0, y: 32'd0, z: 32'd0, w: 32'(width_reg), h: HEIGHT_TOP,
                     d: 32'(depth_reg)};
    free_n = 1;
  endfunction

  function automatic void append_box(logic [31:0] x, y, z, w, h, d);
    if (free_n < LIST_SIZE) begin
      free_list[free_n] = '{x: x, y: y, z: z, w: w, h: h, d: d};
      free_n++;
    end
  endfunction

  // Work out the result of one request and update the free list.
  function automatic placement_t place_box(logic k, logic [15:0] bw, bh, bd);
    placement_t  r;
    logic [31:0] ow [6];
    logic [31:0] oh [6];
    logic [31:0] od [6];
    logic [31:0] w32, h32, d32;
    logic [31:0] score, best_score;
    logic [31:0] pw, ph, pd, top_h;
    logic        found, horiz;
    int          best;
    free_box_t   fb;
    r = '{default: '0};
    found = 0;
    best = 0;
    best_score = 0;
    pw = 0; ph = 0; pd = 0;
    if (k == gbp_pkg::KIND_NEW_BIN) begin
      open_bin();
      return r;
    end
    if (free_n + 2 > LIST_SIZE) begin
      r.full = 1;
      return r;
    end
    w32 = 32'(bw);
    h32 = 32'(bh);
    d32 = 32'(bd);
    ow = '{w32, w32, d32, d32, h32, h32};
    oh = '{h32, d32, h32, w32, w32, d32};
    od = '{d32, h32, w32, h32, d32, w32};
    // Scan in order; the first strictly lowest score wins.
    for (int i = 0; i < free_n; i++) begin
      score = free_list[i].y + h32;
      for (int o = 0; o < 6; o++) begin
        if (ow[o] <= free_list[i].w && oh[o] <= free_list[i].h && od[o] <= free_list[i].d &&
            free_list[i].y + oh[o] <= HEIGHT_TOP && (!found || score < best_score)) begin
          found = 1;
          best_score = score;
          best = i;
          pw = ow[o]; ph = oh[o]; pd = od[o];
        end
      end
    end
    if (!found) return r;
    fb = free_list[best];
    for (int i = best; i + 1 < free_n; i++) free_list[i] = free_list[i + 1];
    free_n--;
    case (rule_reg)
      gbp_pkg::RULE_SHORT_LEFT: horiz = (fb.w - pw) <= (fb.d - pd);
      gbp_pkg::RULE_LONG_LEFT:  horiz = (fb.w - pw) > (fb.d - pd);
      gbp_pkg::RULE_SHORT_AXIS: horiz = fb.w <= fb.d;
      default:                  horiz = fb.w > fb.d;
    endcase
    // An unbounded free box keeps an unbounded top.
    top_h = (fb.h == HEIGHT_TOP) ? HEIGHT_TOP : fb.h - ph;
    append_box(fb.x, fb.y, fb.z + pd, horiz ? fb.w : pw, ph, fb.d - pd);
    append_box(fb.x + pw, fb.y, fb.z, fb.w - pw, ph, horiz ? pd : fb.d);
    append_box(fb.x, fb.y + ph, fb.z, fb.w, top_h, fb.d);
    r.placed = 1;
    r.x = fb.x[15:0];
    r.y = fb.y[HEIGHT_BITS-1:0];
    r.z = fb.z[15:0];
    r.w = pw[15:0];
    r.h = ph[15:0];
    r.d = pd[15:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
    end
  endtask

  // Track registers, predict accepted requests and compare accepted results.
  always @(posedge clk) begin
    placement_t exp_r;
    placement_t new_r;
    if (rst) begin
      errors    = 0;
      width_reg = 16'd1024;
      depth_reg = 16'd1024;
      rule_reg  = gbp_pkg::RULE_SHORT_LEFT;
      open_bin();
      placements_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gbp_pkg::CFG_BIN_WIDTH:  width_reg = cfg_data;
          gbp_pkg::CFG_BIN_DEPTH:  depth_reg = cfg_data;
          gbp_pkg::CFG_SPLIT_RULE: rule_reg  = cfg_data[1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (placements_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result transaction", $realtime);
        end else begin
          exp_r = placements_due.pop_front();
          check_field("placed", 32'(exp_r.placed), 32'(placed));
          check_field("table_full", 32'(exp_r.full), 32'(table_full));
          check_field("pos_x", 32'(exp_r.x), 32'(pos_x));
          check_field("pos_y", 32'(exp_r.y), 32'(pos_y));
          check_field("pos_z", 32'(exp_r.z), 32'(pos_z));
          check_field("placed_width", 32'(exp_r.w), 32'(placed_width));
          check_field("placed_height", 32'(exp_r.h), 32'(placed_height));
          check_field("placed_depth", 32'(exp_r.d), 32'(placed_depth));
        end
      end
      if (in_valid && !in_stall) begin
        new_r = place_box(kind, box_width, box_height, box_depth);
        placements_due.insert(placements_due.size(), new_r);
      end
    end
  end

endmodule

[verif/tb_guillotine_box_placer_3d.sv]
// Testbench top of the guillotine box placer: clock, reset, stimulus and verdict.
// Depends on gbp_pkg, the placer RTL and gbp_place_checker.
`timescale 1ns / 1ps

module tb_guillotine_box_placer_3d;

  localparam int CYCLE_LIMIT = 1500000;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_stall;
  logic        kind = gbp_pkg::KIND_NEW_BIN;
  logic [15:0] box_width = '0, box_height = '0, box_depth = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        placed, table_full;
  logic [15:0] pos_x, pos_z, placed_width, placed_height, placed_depth;
  logic [23:0] pos_y;
  int          errors, outstanding;
  int          cycles = 0;
  bit          quiet = 0;
  bit          hold_req = 0;
  bit          hold_done = 0;
  logic [15:0] cur_w = 16'd1024, cur_d = 16'd1024;

  guillotine_box_placer_3d i_dut (.*);

  gbp_place_checker i_checker (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_guillotine_box_placer_3d failed");
      $finish;
    end
  end

  // Receiver stalls: random bursts, one long hold on request, none at the end.
  initial begin
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1;
        repeat (400) @(posedge clk);
        hold_done = 1;
      end else if (quiet) begin
        out_stall <= 0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // Offer one request and hold it until accepted, then maybe leave a gap.
  task automatic send_req(logic k, logic [15:0] w, h, d);
    in_valid   <= 1;
    kind       <= k;
    box_width  <= w;
    box_height <= h;
    box_depth  <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Stop offering, wait for every result and let the block settle.
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] w, d, logic [1:0] rule);
    cfg_we <= 1; cfg_index <= gbp_pkg::CFG_BIN_WIDTH; cfg_data <= w;
    @(posedge clk);
    cfg_index <= gbp_pkg::CFG_BIN_DEPTH; cfg_data <= d;
    @(posedge clk);
    cfg_index <= gbp_pkg::CFG_SPLIT_RULE; cfg_data <= {14'($urandom), rule};
    @(posedge clk);
    cfg_we <= 0;
    cur_w = w;
    cur_d = d;
  endtask

  // Box extent: mostly scaled to the bin, sometimes zero or anything.
  function automatic logic [15:0] pick_dim();
    int unsigned span;
    int unsigned sel;
    span = (cur_w > cur_d ? cur_w : cur_d) / 3 + 1;
    sel = $urandom_range(0, 19);
    if (sel == 0) return '0;
    if (sel < 4) return 16'($urandom);
    return 16'($urandom_range(1, span));
  endfunction

  initial begin
    logic [15:0] widths [8];
    logic [15:0] depths [8];
    int          runs;
    widths = '{16'd1, 16'd65535, 16'd300, 16'd1, 16'd65535, 16'd64, 16'd4000, 16'd777};
    depths = '{16'd1, 16'd65535, 16'd300, 16'd65535, 16'd1, 16'd200, 16'd90, 16'd777};
    repeat (2) @(posedge clk);
    rst <= 0;

    // Directed: exact fit, oversize, zero and maximal extents, rotations.
    send_req(gbp_pkg::KIND_PLACE, 16'd1024, 16'd1024, 16'd1024);
    send_req(gbp_pkg::KIND_PLACE, 16'd0, 16'd0, 16'd0);
    send_req(gbp_pkg::KIND_PLACE, 16'd65535, 16'd65535, 16'd65535);
    send_req(gbp_pkg::KIND_PLACE, 16'd65535, 16'd1, 16'd1);
    send_req(gbp_pkg::KIND_PLACE, 16'd1, 16'd65535, 16'd1);
    send_req(gbp_pkg::KIND_PLACE, 16'd1100, 16'd500, 16'd100);
    send_req(gbp_pkg::KIND_NEW_BIN, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_req(gbp_pkg::KIND_PLACE, 16'd100, 16'd2000, 16'd30);
    for (int i = 0; i < 18; i++) send_req(gbp_pkg::KIND_PLACE, 16'd10, 16'd10, 16'd10);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      set_config(widths[phase], depths[phase], 2'(phase));
      if (phase == 7) quiet = 1;
      runs = 0;
      while (runs < 170) begin
        send_req(gbp_pkg::KIND_NEW_BIN, 16'($urandom), 16'($urandom), 16'($urandom));
        runs++;
        if (phase == 3 && runs == 40) hold_req = 1;
        repeat ($urandom_range(1, 36)) begin
          send_req(gbp_pkg::KIND_PLACE, pick_dim(), pick_dim(), pick_dim());
          runs++;
        end
      end
      drain();
    end

    if (errors == 0 && outstanding == 0) begin
      $display("tb_guillotine_box_placer_3d passed");
    end else begin
      $display("tb_guillotine_box_placer_3d failed");
    end
    $finish;
  end

endmodule
